// File: rtl/core/alrc_pkg.sv
`timescale 1ns / 1ps

package alrc_pkg;

  // ASCII codes that the calculator recognizes.
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam int unsigned VALUE_BITS = 32;

endpackage

// File: rtl/core/ascii_left_to_right_calculator_core.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i, in_stall_o  | char_code_i[7:0], end_of_expr_i
// result  | out       | out_valid_o, out_stall_i| value_o[31:0] (signed), div_zero_o
//
// A digit, or an operator with no number pending, is accepted in the idle state.
// Closing a number with + or - runs the execute step, with * also the multiply
// steps and with / the divide steps; the shared adder steps one bit per cycle.
// A final character adds the emit step, which loads the result register.
// Reset clears all state; the result register holds while out_stall_i is high,
// and a new final result waits until the previous one has been transferred.

module ascii_left_to_right_calculator_core
  import alrc_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   char_code_i,
  input  logic                         end_of_expr_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic                         div_zero_o
);

  localparam int unsigned CntBits = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_NEG,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [WORD_BITS-1:0]   acc_q;
  logic [WORD_BITS-1:0]   number_q;
  logic [7:0]             pending_q;
  logic                   have_q;
  logic                   dz_q;
  logic                   last_q;
  logic [7:0]             op_q;
  logic [WORD_BITS-1:0]   b_q;
  logic [WORD_BITS-1:0]   mcand_q;
  logic [WORD_BITS-1:0]   work_q;   // multiplier bits, or dividend bits
  logic [WORD_BITS-1:0]   part_q;   // running product, or remainder
  logic                   neg_q;
  logic [CntBits-1:0]     cnt_q;
  logic                   out_valid_q;
  logic signed [VALUE_BITS-1:0] value_q;
  logic                   div_zero_q;

  logic                   in_xfer;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [WORD_BITS-1:0]   number_next;
  logic [WORD_BITS-1:0]   alu_a;
  logic [WORD_BITS-1:0]   alu_b;
  logic                   alu_cin;
  logic [WORD_BITS:0]     alu_sum;
  logic                   div_ge;
  logic [WORD_BITS-1:0]   div_shift;
  logic [WORD_BITS-1:0]   acc_mag;
  logic [WORD_BITS-1:0]   b_mag;
  logic                   emit_ok;
  state_e                 done_state;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign div_zero_o  = div_zero_q;

  assign is_digit    = char_code_i inside {[CHAR_0:CHAR_9]};
  assign digit       = 4'(char_code_i - CHAR_0);
  assign number_next = (number_q << 3) + (number_q << 1) + WORD_BITS'(digit);

  assign div_shift   = {part_q[WORD_BITS-2:0], work_q[WORD_BITS-1]};
  assign acc_mag     = acc_q[WORD_BITS-1] ? (~acc_q + 1'b1) : acc_q;
  assign b_mag       = b_q[WORD_BITS-1] ? (~b_q + 1'b1) : b_q;
  assign emit_ok     = !out_valid_q || !out_stall_i;
  assign done_state  = last_q ? ST_EMIT : ST_IDLE;

  // The adder shared by the add, subtract, multiply, divide and negate steps.
  always_comb begin
    alu_a   = acc_q;
    alu_b   = b_q;
    alu_cin = 1'b0;
    case (state_q)
      ST_EXEC: begin
        if (op_q == CHAR_MINUS) begin
          alu_b   = ~b_q;
          alu_cin = 1'b1;
        end
      end
      ST_MUL: begin
        alu_a = part_q;
        alu_b = work_q[0] ? mcand_q : '0;
      end
      ST_DIV: begin
        alu_a   = div_shift;
        alu_b   = ~mcand_q;
        alu_cin = 1'b1;
      end
      ST_NEG: begin
        alu_a   = '0;
        alu_b   = ~acc_q;
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = acc_q;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (WORD_BITS + 1)'(alu_cin);
  assign div_ge  = alu_sum[WORD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      number_q    <= '0;
      pending_q   <= CHAR_PLUS;
      have_q      <= 1'b0;
      dz_q        <= 1'b0;
      last_q      <= 1'b0;
      op_q        <= CHAR_PLUS;
      b_q         <= '0;
      mcand_q     <= '0;
      work_q      <= '0;
      part_q      <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      div_zero_q  <= 1'b0;
    end else begin
      // The emit step reloads the result register itself.
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            last_q <= end_of_expr_i;
            op_q   <= pending_q;
            if (is_digit) begin
              number_q <= number_next;
              have_q   <= 1'b1;
              b_q      <= number_next;
              if (end_of_expr_i) begin
                state_q <= ST_EXEC;
              end
            end else begin
              pending_q <= char_code_i;
              b_q       <= number_q;
              if (have_q) begin
                state_q <= ST_EXEC;
              end else if (end_of_expr_i) begin
                state_q <= ST_EMIT;
              end
            end
          end
        end
        ST_EXEC: begin
          number_q <= '0;
          have_q   <= 1'b0;
          cnt_q    <= CntBits'(WORD_BITS);
          state_q  <= done_state;
          case (op_q)
            CHAR_PLUS, CHAR_MINUS: begin
              acc_q <= alu_sum[WORD_BITS-1:0];
            end
            CHAR_STAR: begin
              mcand_q <= acc_q;
              work_q  <= b_q;
              part_q  <= '0;
              state_q <= ST_MUL;
            end
            CHAR_SLASH: begin
              if (b_q == '0) begin
                acc_q <= '0;
                dz_q  <= 1'b1;
              end else begin
                mcand_q <= b_mag;
                work_q  <= acc_mag;
                part_q  <= '0;
                neg_q   <= acc_q[WORD_BITS-1] ^ b_q[WORD_BITS-1];
                state_q <= ST_DIV;
              end
            end
            default: begin
              acc_q <= '0;
            end
          endcase
        end
        ST_MUL: begin
          part_q  <= alu_sum[WORD_BITS-1:0];
          mcand_q <= mcand_q << 1;
          work_q  <= work_q >> 1;
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            acc_q   <= alu_sum[WORD_BITS-1:0];
            state_q <= done_state;
          end
        end
        ST_DIV: begin
          // Restoring division: keep the trial difference when it did not borrow.
          part_q <= div_ge ? alu_sum[WORD_BITS-1:0] : div_shift;
          work_q <= {work_q[WORD_BITS-2:0], div_ge};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CntBits'(1)) begin
            acc_q   <= {work_q[WORD_BITS-2:0], div_ge};
            state_q <= neg_q ? ST_NEG : done_state;
          end
        end
        ST_NEG: begin
          acc_q   <= alu_sum[WORD_BITS-1:0];
          state_q <= done_state;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            value_q     <= VALUE_BITS'($signed(acc_q));
            div_zero_q  <= dz_q;
            acc_q       <= '0;
            number_q    <= '0;
            pending_q   <= CHAR_PLUS;
            have_q      <= 1'b0;
            dz_q        <= 1'b0;
            last_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result register loaded outside the emit step");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && end_of_expr_i) |=> in_stall_o)
    else $error("final character did not start result processing");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_ok) |=>
      (!have_q && !dz_q && acc_q == '0 && pending_q == CHAR_PLUS))
    else $error("expression state not cleared after a result");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> cnt_q != '0)
    else $error("bit counter empty during an iterative step");
`endif

endmodule

// File: bench/tb_ascii_left_to_right_calculator_core.sv
`timescale 1ns / 1ps

module tb_ascii_left_to_right_calculator_core;
  import alrc_pkg::*;

  localparam int unsigned CALC_WORD_BITS  = 32;
  localparam int unsigned DRAIN_CYCLES    = CALC_WORD_BITS + 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         div_zero;
  } calc_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [7:0]                   char_code_i   = 8'h00;
  logic                         end_of_expr_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic signed [VALUE_BITS-1:0] value_o;
  logic                         div_zero_o;

  ascii_left_to_right_calculator_core #(
    .WORD_BITS(CALC_WORD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_expr_i (end_of_expr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .div_zero_o    (div_zero_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  int unsigned  sender_idle_pct    = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  items_sent         = 0;
  int unsigned  mismatch_count     = 0;
  int unsigned  cycle_count        = 0;
  calc_result_t expected_results[$];
  calc_result_t wanted_result;

  // Predicted calculator state.
  logic [CALC_WORD_BITS-1:0] running_total;
  logic [CALC_WORD_BITS-1:0] digits_value;
  logic [7:0]                pending_operator;
  logic                      number_open;
  logic                      div_zero_seen;

  task automatic clear_prediction();
    running_total    = '0;
    digits_value     = '0;
    pending_operator = CHAR_PLUS;
    number_open      = 1'b0;
    div_zero_seen    = 1'b0;
  endtask

  function automatic logic [CALC_WORD_BITS-1:0] apply_operator(
      input logic [CALC_WORD_BITS-1:0] lhs,
      input logic [CALC_WORD_BITS-1:0] rhs,
      input logic [7:0]                op);
    logic [CALC_WORD_BITS-1:0] lhs_mag;
    logic [CALC_WORD_BITS-1:0] rhs_mag;
    logic [CALC_WORD_BITS-1:0] quotient;
    lhs_mag = lhs[CALC_WORD_BITS-1] ? -lhs : lhs;
    rhs_mag = rhs[CALC_WORD_BITS-1] ? -rhs : rhs;
    case (op)
      CHAR_PLUS:  return lhs + rhs;
      CHAR_MINUS: return lhs - rhs;
      CHAR_STAR:  return lhs * rhs;
      CHAR_SLASH: begin
        if (rhs == '0) return '0;
        // Divide magnitudes so that the most negative value over -1 wraps to itself.
        quotient = lhs_mag / rhs_mag;
        return (lhs[CALC_WORD_BITS-1] ^ rhs[CALC_WORD_BITS-1]) ? -quotient : quotient;
      end
      default:    return '0;
    endcase
  endfunction

  task automatic close_number();
    if (number_open) begin
      if (pending_operator == CHAR_SLASH && digits_value == '0) div_zero_seen = 1'b1;
      running_total = apply_operator(running_total, digits_value, pending_operator);
      digits_value  = '0;
      number_open   = 1'b0;
    end
  endtask

  task automatic predict_char(input logic [7:0] ch, input logic last);
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      digits_value = digits_value * 32'd10 + (ch - CHAR_0);
      number_open  = 1'b1;
    end else begin
      close_number();
      pending_operator = ch;
    end
    if (last) begin
      close_number();
      expected_results.push_back('{value: running_total, div_zero: div_zero_seen});
      clear_prediction();
    end
  endtask

  task automatic report_mismatch(input string what, input calc_result_t want,
                                 input calc_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: %s: expected value %0d div_zero %0b, got value %0d div_zero %0b",
               $time, what, want.value, want.div_zero, got.value, got.div_zero);
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    char_code_i   <= ch;
    end_of_expr_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_char(ch, last);
    items_sent++;
  endtask

  task automatic send_text(input string text, input bit last_flag);
    for (int i = 0; i < text.len(); i++)
      send_char(text[i], last_flag && (i == text.len() - 1));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_number(input bit last_flag);
    int unsigned pick;
    int unsigned digit_count;
    pick = $urandom_range(99, 0);
    if (pick < 8) begin
      send_text("0", last_flag);
    end else if (pick < 13) begin
      send_text("2147483648", last_flag);
    end else if (pick < 18) begin
      // All ones: minus one as a signed divisor or factor.
      send_text("4294967295", last_flag);
    end else begin
      digit_count = (pick < 75) ? $urandom_range(3, 1) : $urandom_range(14, 4);
      for (int i = 0; i < digit_count; i++)
        send_char(CHAR_0 + 8'($urandom_range(9, 0)), last_flag && (i == digit_count - 1));
    end
  endtask

  task automatic send_operator(input bit last_flag);
    logic [7:0] ch;
    if ($urandom_range(99, 0) < 88) begin
      case ($urandom_range(3, 0))
        0:       ch = CHAR_PLUS;
        1:       ch = CHAR_MINUS;
        2:       ch = CHAR_STAR;
        default: ch = CHAR_SLASH;
      endcase
    end else begin
      do ch = 8'($urandom_range(255, 0)); while (ch >= CHAR_0 && ch <= CHAR_9);
    end
    send_char(ch, last_flag);
  endtask

  task automatic send_expression();
    int unsigned terms;
    bit          trailing_op;
    terms       = $urandom_range(5, 1);
    trailing_op = ($urandom_range(99, 0) < 12);
    if ($urandom_range(9, 0) == 0) send_operator(1'b0);
    for (int t = 0; t < terms; t++) begin
      send_number((t == terms - 1) && !trailing_op);
      if (t != terms - 1) begin
        send_operator(1'b0);
        if ($urandom_range(99, 0) < 8) send_operator(1'b0);
      end
    end
    if (trailing_op) send_operator(1'b1);
  endtask

  task automatic send_noise();
    int unsigned count;
    count = $urandom_range(8, 1);
    for (int i = 0; i < count; i++)
      send_char(8'($urandom_range(255, 0)), i == count - 1);
  endtask

  task automatic test_all_operators();
    send_text("9+8-3*5/4", 1'b1);
  endtask

  task automatic test_signed_division();
    send_text("0-7/2", 1'b1);
  endtask

  task automatic test_divide_by_zero();
    send_text("5/0", 1'b1);
  endtask

  // Unknown codes, operators in a row, and an expression that ends on an operator.
  task automatic test_odd_operators();
    send_char("3", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_STAR, 1'b0);
    send_char("4", 1'b0);
    send_char(8'h00, 1'b1);
    send_char("2", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("5", 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target             = items_sent + ITEMS_PER_PHASE;
    while (items_sent < target) begin
      if ($urandom_range(99, 0) < 15) send_noise();
      else send_expression();
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, '{value: value_o, div_zero: div_zero_o});
      end else begin
        wanted_result = expected_results.pop_front();
        if (value_o !== wanted_result.value || div_zero_o !== wanted_result.div_zero)
          report_mismatch("result mismatch", wanted_result,
                          '{value: value_o, div_zero: div_zero_o});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clear_prediction();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_all_operators();
    test_signed_division();
    test_divide_by_zero();
    test_odd_operators();
    drain();

    test_random_traffic(0, 0);
    test_random_traffic(60, 0);
    test_random_traffic(0, 60);
    test_random_traffic(29, 29);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
